// ----- rtl/core/ostt_pkg.sv -----
package ostt_pkg;

	localparam int NUM_SLOTS = 16;
	// The 4-bit timer_id reaches at most 16 slots.
	localparam int USABLE_SLOTS = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
	localparam int SLOT_W = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;

	localparam int EXP_W = 64;
	localparam int PER_W = 32;
	localparam int MEM_W = EXP_W + PER_W;

	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_ONE   = 3'd1,
		ACT_PER   = 3'd2,
		ACT_STOP  = 3'd3,
		ACT_DEL   = 3'd4,
		ACT_QUERY = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_BAD_PARAM = 2'd1,
		STS_BAD_STATE = 2'd2
	} status_t;

endpackage

// ----- rtl/core/ostt_if.sv -----
interface ostt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [3:0]  timer_id;
	logic [31:0] delay_ticks;
	logic [31:0] reload_ticks;

	modport source (output valid, action, timer_id, delay_ticks, reload_ticks, input ready);
	modport sink (input valid, action, timer_id, delay_ticks, reload_ticks, output ready);
endinterface

interface ostt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       fired;
	logic [3:0] slot;
	logic       is_active;
	logic       last;

	modport source (output valid, status, fired, slot, is_active, last, input ready);
	modport sink (input valid, status, fired, slot, is_active, last, output ready);
endinterface

// ----- rtl/core/ostt_slot_ram.sv -----
module ostt_slot_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]      wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]      rd_data_s1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

endmodule

// ----- rtl/core/one_shot_periodic_timer_table.sv -----
// A start, stop, delete or query passes through the command state, and its result is then
// registered into the output; a stall on the result side holds it in the command state.
// A tick scans the slot memory once per fired slot, or once if none fires, one entry a
// cycle through its single read port; a stall on the result side holds the fire or empty
// state, never a scan. Commands are taken only in the idle state, so the next transfer
// waits until the previous command or tick has loaded its last result.
// Reset clears the tick count and the active and periodic flags at once; the expiry/period
// memory is not cleared, since an entry is always written before a flag makes it readable.
module one_shot_periodic_timer_table (
	input  logic         clk,
	input  logic         arst_n,
	ostt_in_if.sink      cmd,
	ostt_out_if.source   res
);

	import ostt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_SCAN,
		ST_FIRE,
		ST_EMPTY
	} state_t;

	state_t                    state_q;
	logic [EXP_W-1:0]          count_q;
	logic [USABLE_SLOTS-1:0]   active_q;
	logic [USABLE_SLOTS-1:0]   periodic_q;
	logic [USABLE_SLOTS-1:0]   due_q;

	logic [2:0]                act_q;
	logic [3:0]                id_q;
	logic [31:0]               delay_q;
	logic [31:0]               period_q;

	logic [SLOT_W-1:0]         rd_idx_q;
	logic                      issuing_q;
	logic                      first_pass_q;
	logic                      rd_vld_s1;
	logic [SLOT_W-1:0]         idx_s1;
	logic [MEM_W-1:0]          ram_rdata_s1;

	logic                      best_vld_q;
	logic [SLOT_W-1:0]         best_idx_q;
	logic [EXP_W-1:0]          best_exp_q;
	logic [PER_W-1:0]          best_per_q;

	logic                      out_valid_q;
	logic [1:0]                res_status_q;
	logic                      res_fired_q;
	logic [3:0]                res_slot_q;
	logic                      res_active_q;
	logic                      res_last_q;

	logic                      cmd_xfer;
	logic                      res_free;
	logic                      res_load;
	logic                      id_ok;
	logic [SLOT_W-1:0]         sel_idx;
	logic                      cur_active;
	logic [1:0]                cmd_status;
	logic                      cmd_active;
	logic                      cmd_write;

	logic [EXP_W-1:0]          rd_exp;
	logic [PER_W-1:0]          rd_per;
	logic                      cand;
	logic                      nb_vld;
	logic [SLOT_W-1:0]         nb_idx;
	logic [EXP_W-1:0]          nb_exp;
	logic [PER_W-1:0]          nb_per;
	logic                      scan_end;
	logic                      fire_last;
	logic [USABLE_SLOTS-1:0]   best_mask;
	logic [PER_W-1:0]          rearm_per;

	logic                      ram_we;
	logic [SLOT_W-1:0]         ram_waddr;
	logic [MEM_W-1:0]          ram_wdata;

	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign res_free  = !out_valid_q || res.ready;
	// A new result is loaded into the output register this cycle.
	assign res_load  = res_free &&
		((state_q == ST_CMD) || (state_q == ST_FIRE) || (state_q == ST_EMPTY));

	assign res.valid     = out_valid_q;
	assign res.status    = res_status_q;
	assign res.fired     = res_fired_q;
	assign res.slot      = res_slot_q;
	assign res.is_active = res_active_q;
	assign res.last      = res_last_q;

	assign id_ok      = int'(id_q) < USABLE_SLOTS;
	assign sel_idx    = id_q[SLOT_W-1:0];
	assign cur_active = active_q[sel_idx];

	// Outcome of a single-slot command, as seen after the action.
	always_comb begin
		cmd_status = STS_OK;
		cmd_active = cur_active;
		cmd_write  = 1'b0;
		if (!id_ok) begin
			cmd_status = STS_BAD_PARAM;
			cmd_active = 1'b0;
		end else begin
			case (act_q)
				ACT_ONE: begin
					cmd_active = 1'b1;
					cmd_write  = 1'b1;
				end
				ACT_PER: begin
					if (period_q == '0) begin
						cmd_status = STS_BAD_PARAM;
					end else begin
						cmd_active = 1'b1;
						cmd_write  = 1'b1;
					end
				end
				ACT_STOP: begin
					if (!cur_active) begin
						cmd_status = STS_BAD_STATE;
					end
					cmd_active = 1'b0;
				end
				ACT_DEL: begin
					cmd_active = 1'b0;
				end
				ACT_QUERY: begin
					cmd_active = cur_active;
				end
				default: begin
					cmd_status = STS_BAD_PARAM;
				end
			endcase
		end
	end

	assign rd_exp = ram_rdata_s1[MEM_W-1:PER_W];
	assign rd_per = ram_rdata_s1[PER_W-1:0];

	// The first pass decides which slots are due; later passes only pick among them.
	// Scanning in ascending index with a strict compare keeps the lower slot on a tie.
	always_comb begin
		cand = first_pass_q ? (active_q[idx_s1] && (rd_exp <= count_q)) : due_q[idx_s1];
		nb_vld = best_vld_q;
		nb_idx = best_idx_q;
		nb_exp = best_exp_q;
		nb_per = best_per_q;
		if (rd_vld_s1 && cand && (!best_vld_q || (rd_exp < best_exp_q))) begin
			nb_vld = 1'b1;
			nb_idx = idx_s1;
			nb_exp = rd_exp;
			nb_per = rd_per;
		end
	end

	assign scan_end  = rd_vld_s1 && (idx_s1 == SLOT_W'(USABLE_SLOTS - 1));
	assign best_mask = USABLE_SLOTS'(1) << best_idx_q;
	assign fire_last = (due_q & ~best_mask) == '0;
	assign rearm_per = (best_per_q == '0) ? PER_W'(1) : best_per_q;

	// Memory writes happen only in the command and fire states, never while a scan
	// is reading, so a scan read never meets a write to the same entry.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sel_idx;
		ram_wdata = {count_q + EXP_W'(delay_q), (act_q == ACT_PER) ? period_q : PER_W'(0)};
		if (state_q == ST_CMD) begin
			ram_we = res_free && cmd_write;
		end else if (state_q == ST_FIRE) begin
			ram_we    = res_free && periodic_q[best_idx_q];
			ram_waddr = best_idx_q;
			ram_wdata = {count_q + EXP_W'(rearm_per), best_per_q};
		end
	end

	ostt_slot_ram #(
		.WIDTH (MEM_W),
		.DEPTH (USABLE_SLOTS)
	) u_slot_ram (
		.clk        (clk),
		.wr_en      (ram_we),
		.wr_addr    (ram_waddr),
		.wr_data    (ram_wdata),
		.rd_addr    (rd_idx_q),
		.rd_data_s1 (ram_rdata_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			active_q     <= '0;
			periodic_q   <= '0;
			due_q        <= '0;
			act_q        <= ACT_TICK;
			id_q         <= '0;
			delay_q      <= '0;
			period_q     <= '0;
			rd_idx_q     <= '0;
			issuing_q    <= 1'b0;
			first_pass_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
			best_vld_q   <= 1'b0;
			best_idx_q   <= '0;
			best_exp_q   <= '0;
			best_per_q   <= '0;
			out_valid_q  <= 1'b0;
			res_status_q <= STS_OK;
			res_fired_q  <= 1'b0;
			res_slot_q   <= '0;
			res_active_q <= 1'b0;
			res_last_q   <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			rd_vld_s1 <= issuing_q;
			idx_s1    <= rd_idx_q;
			if (issuing_q) begin
				if (rd_idx_q == SLOT_W'(USABLE_SLOTS - 1)) begin
					issuing_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						act_q    <= cmd.action;
						id_q     <= cmd.timer_id;
						delay_q  <= cmd.delay_ticks;
						period_q <= cmd.reload_ticks;
						if (cmd.action == ACT_TICK) begin
							count_q      <= count_q + 1'b1;
							due_q        <= '0;
							first_pass_q <= 1'b1;
							best_vld_q   <= 1'b0;
							rd_idx_q     <= '0;
							issuing_q    <= 1'b1;
							state_q      <= ST_SCAN;
						end else begin
							state_q <= ST_CMD;
						end
					end
				end
				ST_CMD: begin
					if (res_free) begin
						res_status_q <= cmd_status;
						res_fired_q  <= 1'b0;
						res_slot_q   <= id_q;
						res_active_q <= cmd_active;
						res_last_q   <= 1'b1;
						if (id_ok) begin
							active_q[sel_idx] <= cmd_active;
							if (cmd_write) begin
								periodic_q[sel_idx] <= (act_q == ACT_PER);
							end else if (act_q == ACT_DEL) begin
								periodic_q[sel_idx] <= 1'b0;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					best_vld_q <= nb_vld;
					best_idx_q <= nb_idx;
					best_exp_q <= nb_exp;
					best_per_q <= nb_per;
					if (first_pass_q && rd_vld_s1 && cand) begin
						due_q[idx_s1] <= 1'b1;
					end
					if (scan_end) begin
						if (nb_vld) begin
							state_q <= ST_FIRE;
						end else if (first_pass_q) begin
							state_q <= ST_EMPTY;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIRE: begin
					if (res_free) begin
						res_status_q <= STS_OK;
						res_fired_q  <= 1'b1;
						res_slot_q   <= 4'(best_idx_q);
						res_active_q <= periodic_q[best_idx_q];
						res_last_q   <= fire_last;
						due_q[best_idx_q] <= 1'b0;
						if (!periodic_q[best_idx_q]) begin
							active_q[best_idx_q] <= 1'b0;
						end
						if (fire_last) begin
							state_q <= ST_IDLE;
						end else begin
							first_pass_q <= 1'b0;
							best_vld_q   <= 1'b0;
							rd_idx_q     <= '0;
							issuing_q    <= 1'b1;
							state_q      <= ST_SCAN;
						end
					end
				end
				ST_EMPTY: begin
					if (res_free) begin
						res_status_q <= STS_OK;
						res_fired_q  <= 1'b0;
						res_slot_q   <= '0;
						res_active_q <= 1'b0;
						res_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_due_is_active: assert property (@(posedge clk) disable iff (!arst_n)
		(due_q & ~active_q) == '0)
		else $error("due slot is not active");

	a_idle_no_due: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (due_q == '0))
		else $error("due slots left over after a tick");

	a_one_shot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRE && res_free && !periodic_q[best_idx_q])
		|=> !active_q[$past(best_idx_q)])
		else $error("fired one-shot slot still active");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_xfer && cmd.action == ACT_TICK) |=> (count_q == $past(count_q) + 1'b1))
		else $error("tick count did not advance by one");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import ostt_pkg::*;

	// Action codes the block does not define; both must be rejected.
	localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
	localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_PER_PHASE = 110;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  timer_id;
		logic [31:0] delay;
		logic [31:0] period;
	} timer_cmd_t;

	typedef struct packed {
		status_t    status;
		logic       fired;
		logic [3:0] slot;
		logic       is_active;
		logic       last;
	} timer_report_t;

	// One directed command; when typed is set, the single report is written out here.
	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  timer_id;
		logic [31:0] delay;
		logic [31:0] period;
		logic        typed;
		status_t     status;
		logic        is_active;
	} directed_row_t;

	logic clk;
	logic arst_n;

	ostt_in_if  cmd ();
	ostt_out_if res ();

	one_shot_periodic_timer_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	// Shadow copy of the timer table.
	logic [63:0] now_ticks;
	logic [63:0] slot_expiry [NUM_SLOTS];
	logic [31:0] slot_period [NUM_SLOTS];
	logic        slot_on     [NUM_SLOTS];
	logic        slot_repeat [NUM_SLOTS];

	timer_report_t step_reports [$];
	timer_report_t pending_reports [$];
	timer_report_t want;

	int errors;
	int tx_idle_pct;
	int rx_stall_pct;

	directed_row_t plan [DIRECTED_ROWS] = '{
		'{ACT_TICK,     4'd0,  32'd0,         32'd0,         1'b1, STS_OK,        1'b0},
		'{ACT_QUERY,    4'd15, 32'd0,         32'd0,         1'b1, STS_OK,        1'b0},
		'{ACT_STOP,     4'd3,  32'd0,         32'd0,         1'b1, STS_BAD_STATE, 1'b0},
		'{ACT_PER,      4'd7,  32'd5,         32'd0,         1'b1, STS_BAD_PARAM, 1'b0},
		'{ACT_UNDEF_LO, 4'd2,  32'd0,         32'd0,         1'b1, STS_BAD_PARAM, 1'b0},
		'{ACT_UNDEF_HI, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STS_BAD_PARAM, 1'b0},
		'{ACT_ONE,      4'd4,  32'd1,         32'd0,         1'b1, STS_OK,        1'b1},
		'{ACT_ONE,      4'd10, 32'd0,         32'd0,         1'b1, STS_OK,        1'b1},
		'{ACT_TICK,     4'd0,  32'd0,         32'd0,         1'b0, STS_OK,        1'b0},
		'{ACT_PER,      4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STS_OK,        1'b1},
		'{ACT_TICK,     4'd9,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, STS_OK,        1'b0},
		'{ACT_STOP,     4'd0,  32'd0,         32'd0,         1'b1, STS_OK,        1'b0},
		'{ACT_QUERY,    4'd0,  32'd0,         32'd0,         1'b1, STS_OK,        1'b0},
		'{ACT_DEL,      4'd0,  32'd0,         32'd0,         1'b1, STS_OK,        1'b0},
		'{ACT_PER,      4'd1,  32'd0,         32'd1,         1'b1, STS_OK,        1'b1},
		'{ACT_ONE,      4'd2,  32'd0,         32'd0,         1'b1, STS_OK,        1'b1},
		'{ACT_UNDEF_HI, 4'd1,  32'd0,         32'd0,         1'b1, STS_BAD_PARAM, 1'b1},
		'{ACT_PER,      4'd3,  32'd0,         32'd0,         1'b1, STS_BAD_PARAM, 1'b0},
		'{ACT_TICK,     4'd0,  32'd0,         32'd0,         1'b0, STS_OK,        1'b0},
		'{ACT_TICK,     4'd0,  32'd0,         32'd0,         1'b0, STS_OK,        1'b0},
		'{ACT_ONE,      4'd1,  32'd3,         32'd0,         1'b1, STS_OK,        1'b1},
		'{ACT_STOP,     4'd1,  32'd0,         32'd0,         1'b1, STS_OK,        1'b0},
		'{ACT_STOP,     4'd1,  32'd0,         32'd0,         1'b1, STS_BAD_STATE, 1'b0},
		'{ACT_DEL,      4'd15, 32'd0,         32'd0,         1'b1, STS_OK,        1'b0},
		'{ACT_TICK,     4'd0,  32'd0,         32'd0,         1'b0, STS_OK,        1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL one_shot_periodic_timer_table");
		$finish;
	end

	// Applies one accepted command to the shadow table and leaves its reports in step_reports.
	function automatic void apply_timer_action(input timer_cmd_t c);
		logic        due [NUM_SLOTS];
		logic [31:0] reload;
		int          pick;
		int          s;
		status_t     st;
		timer_report_t r;
		step_reports.delete();
		if (c.action == ACT_TICK) begin
			now_ticks = now_ticks + 64'd1;
			for (int i = 0; i < USABLE_SLOTS; i++)
				due[i] = slot_on[i] && (slot_expiry[i] <= now_ticks);
			for (int k = 0; k < USABLE_SLOTS; k++) begin
				pick = -1;
				for (int i = 0; i < USABLE_SLOTS; i++) begin
					if (due[i] && (pick < 0 || slot_expiry[i] < slot_expiry[pick]))
						pick = i;
				end
				if (pick < 0)
					break;
				due[pick] = 1'b0;
				if (slot_repeat[pick]) begin
					reload = (slot_period[pick] == 32'd0) ? 32'd1 : slot_period[pick];
					slot_expiry[pick] = now_ticks + {32'd0, reload};
				end else begin
					slot_on[pick] = 1'b0;
				end
				r = '{STS_OK, 1'b1, 4'(pick), slot_on[pick], 1'b0};
				step_reports.push_back(r);
			end
			if (step_reports.size() == 0) begin
				r = '{STS_OK, 1'b0, 4'd0, 1'b0, 1'b1};
				step_reports.push_back(r);
			end else begin
				step_reports[step_reports.size() - 1].last = 1'b1;
			end
		end else if (c.timer_id >= USABLE_SLOTS) begin
			r = '{STS_BAD_PARAM, 1'b0, c.timer_id, 1'b0, 1'b1};
			step_reports.push_back(r);
		end else begin
			s = c.timer_id;
			st = STS_OK;
			case (c.action)
				ACT_ONE: begin
					slot_expiry[s] = now_ticks + {32'd0, c.delay};
					slot_period[s] = 32'd0;
					slot_repeat[s] = 1'b0;
					slot_on[s] = 1'b1;
				end
				ACT_PER: begin
					if (c.period == 32'd0) begin
						st = STS_BAD_PARAM;
					end else begin
						slot_expiry[s] = now_ticks + {32'd0, c.delay};
						slot_period[s] = c.period;
						slot_repeat[s] = 1'b1;
						slot_on[s] = 1'b1;
					end
				end
				ACT_STOP: begin
					if (!slot_on[s])
						st = STS_BAD_STATE;
					else
						slot_on[s] = 1'b0;
				end
				ACT_DEL: begin
					slot_expiry[s] = 64'd0;
					slot_period[s] = 32'd0;
					slot_repeat[s] = 1'b0;
					slot_on[s] = 1'b0;
				end
				ACT_QUERY: begin
				end
				default: st = STS_BAD_PARAM;
			endcase
			r = '{st, 1'b0, c.timer_id, slot_on[s], 1'b1};
			step_reports.push_back(r);
		end
	endfunction

	function automatic void check_field(input string name, input logic [3:0] exp_val,
			input logic [3:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
			errors++;
		end
	endfunction

	// Mostly short delays so that slots actually come due; now and then any 32-bit value.
	function automatic logic [31:0] pick_delay();
		if ($urandom_range(9) == 0)
			return $urandom();
		return 32'($urandom_range(4));
	endfunction

	function automatic logic [31:0] pick_period();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 32'd0;
		if (r < 3)
			return $urandom();
		return 32'($urandom_range(1, 4));
	endfunction

	// Tick ignores the other fields, so they are left random.
	function automatic timer_cmd_t tick_cmd();
		timer_cmd_t c;
		c.action = ACT_TICK;
		c.timer_id = 4'($urandom_range(15));
		c.delay = $urandom();
		c.period = $urandom();
		return c;
	endfunction

	function automatic timer_cmd_t random_timer_cmd();
		timer_cmd_t c;
		int r;
		c = tick_cmd();
		c.delay = pick_delay();
		c.period = pick_period();
		r = $urandom_range(99);
		if (r < 30)
			c.action = ACT_TICK;
		else if (r < 48)
			c.action = ACT_ONE;
		else if (r < 66)
			c.action = ACT_PER;
		else if (r < 78)
			c.action = ACT_STOP;
		else if (r < 85)
			c.action = ACT_DEL;
		else if (r < 95)
			c.action = ACT_QUERY;
		else
			c.action = $urandom_range(1) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
		return c;
	endfunction

	task automatic send_timer_cmd(input timer_cmd_t c, input logic typed,
			input timer_report_t typed_rpt);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.action <= c.action;
		cmd.timer_id <= c.timer_id;
		cmd.delay_ticks <= c.delay;
		cmd.reload_ticks <= c.period;
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);
		apply_timer_action(c);
		if (typed) begin
			pending_reports.push_back(typed_rpt);
		end else begin
			foreach (step_reports[i])
				pending_reports.push_back(step_reports[i]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: report with none outstanding, expected none, actual slot %0d",
					$time, res.slot);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", 4'(want.status), 4'(res.status));
				check_field("fired", 4'(want.fired), 4'(res.fired));
				check_field("slot", want.slot, res.slot);
				check_field("is_active", 4'(want.is_active), 4'(res.is_active));
				check_field("last", 4'(want.last), 4'(res.last));
			end
		end
		res.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	initial begin
		timer_cmd_t    c;
		timer_report_t typed_rpt;
		int sent;
		int target;
		int burst;
		int ticks;
		int r;

		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.action = ACT_TICK;
		cmd.timer_id = 4'd0;
		cmd.delay_ticks = 32'd0;
		cmd.reload_ticks = 32'd0;
		errors = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		now_ticks = 64'd0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_expiry[i] = 64'd0;
			slot_period[i] = 32'd0;
			slot_on[i] = 1'b0;
			slot_repeat[i] = 1'b0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			c = '{plan[i].action, plan[i].timer_id, plan[i].delay, plan[i].period};
			typed_rpt = '{plan[i].status, 1'b0, plan[i].timer_id, plan[i].is_active, 1'b1};
			send_timer_cmd(c, plan[i].typed, typed_rpt);
		end

		sent = 0;
		target = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 50;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 50;
				end
				default: begin
					tx_idle_pct = 8;
					rx_stall_pct = 8;
				end
			endcase
			target += RANDOM_PER_PHASE;
			while (sent < target) begin
				r = $urandom_range(99);
				if (r < 60) begin
					send_timer_cmd(random_timer_cmd(), 1'b0, '0);
					sent++;
				end else begin
					// Arm a group of slots with near expiries (in part of the cases), then send one to five ticks.
					// A full group arms every slot, each with its own random delay.
					if (r < 85) begin
						burst = ($urandom_range(3) == 0) ? USABLE_SLOTS : $urandom_range(2, 8);
						for (int k = 0; k < burst; k++) begin
							c = tick_cmd();
							c.action = $urandom_range(1) ? ACT_ONE : ACT_PER;
							c.timer_id = (burst == USABLE_SLOTS) ? 4'(k) : 4'($urandom_range(15));
							c.delay = 32'($urandom_range(3));
							c.period = 32'($urandom_range(1, 4));
							send_timer_cmd(c, 1'b0, '0);
							sent++;
						end
					end
					ticks = $urandom_range(1, 5);
					for (int k = 0; k < ticks; k++) begin
						send_timer_cmd(tick_cmd(), 1'b0, '0);
						sent++;
					end
				end
			end
		end
		cmd.valid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		// Wait on so that any report beyond those expected is still caught.
		repeat (300) @(posedge clk);

		if (errors == 0)
			$display("PASS one_shot_periodic_timer_table");
		else
			$display("FAIL one_shot_periodic_timer_table");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ostt_pkg.sv
rtl/core/ostt_if.sv
rtl/core/ostt_slot_ram.sv
rtl/core/one_shot_periodic_timer_table.sv
tb/sv/testbench.sv
